FILE: hw/rtl/gauss_legendre_node_weight_generator_macros.svh
// Assertion macros shared by the Gauss-Legendre generator RTL.
`ifndef GAUSS_LEGENDRE_NODE_WEIGHT_GENERATOR_MACROS_SVH
`define GAUSS_LEGENDRE_NODE_WEIGHT_GENERATOR_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define GLW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define GLW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/glw_pkg.sv
// Shared constants, types and arithmetic helpers of the Gauss-Legendre generator.
`default_nettype none
package glw_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int FRAC_BITS  = 30;
  localparam int DEG_W      = 5;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int Q_W        = 32;
  localparam int STEP_W     = 31;
  localparam int SW_W       = 21;
  localparam int PROD_W     = 64;
  localparam int T_W        = 34;
  localparam int NUM_W      = 40;
  localparam int DVD_W      = 64;
  localparam int DVS_W      = 41;
  localparam int ITER_W     = 7;
  localparam int NSQ_W      = 9;
  localparam int OMX_W      = 31;
  localparam int QSQ_W      = 33;
  localparam int CFG_IDX_W  = 1;

  localparam logic [ITER_W-1:0] REC_DIV_ITERS = 7'd40;
  localparam logic [ITER_W-1:0] WT_DIV_ITERS  = 7'd64;

  localparam logic signed [Q_W-1:0] ONE_Q     = 32'sh4000_0000;
  localparam logic signed [Q_W-1:0] NEG_ONE_Q = 32'shC000_0000;
  localparam logic [PROD_W-1:0]     HALF_Q    = 64'h0000_0000_2000_0000;
  localparam logic [Q_W-1:0]        WEIGHT_MAX = 32'h8000_0000;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd107374;
  localparam logic [SW_W-1:0]   SW_RESET   = 21'd2;
  localparam logic [SW_W-1:0]   SW_MIN     = 21'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_WIDTH = 1'b1;

  // Source of the polynomial argument.
  typedef enum logic [2:0] {
    EV_X     = 3'd0,
    EV_XSTEP = 3'd1,
    EV_A     = 3'd2,
    EV_MID   = 3'd3,
    EV_C     = 3'd4
  } ev_sel_t;

  // Operand pair of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_PX = 2'd0,
    MUL_CC = 2'd1,
    MUL_PP = 2'd2
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     item_load;
    logic     ev_load;
    ev_sel_t  ev_sel;
    logic     ev_nm1;
    logic     ev_init;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     t_load;
    logic     num1;
    logic     num2;
    logic     div_go_rec;
    logic     ev_upd;
    logic     pref_load;
    logic     scan_adv;
    logic     node_init;
    logic     bis_upd;
    logic     c_latch;
    logic     omx_load;
    logic     q_load;
    logic     den_load;
    logic     div_go_wt;
    logic     w_sat;
    logic     w_load;
    logic     emit;
    logic     emit_none;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deg_zero;
    logic eval_done;
    logic div_done;
    logic scan_more;
    logic cnt_zero;
    logic bis_more;
    logic den_zero;
    logic last_node;
  } sts_t;

  // Rounds a Q x Q product to the fraction width, ties away from zero.
  function automatic logic signed [T_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = p[PROD_W-1] ? (~p + 64'd1) : p;
    r = (mag + HALF_Q) >> FRAC_BITS;
    q_round = p[PROD_W-1] ? -$signed(r[T_W-1:0]) : $signed(r[T_W-1:0]);
  endfunction

  // Saturates to the signed 32-bit range.
  function automatic logic signed [Q_W-1:0] sat32(input logic signed [NUM_W:0] v);
    if (v > $signed({10'b0, 31'h7FFF_FFFF})) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < $signed({10'h3FF, 31'h0})) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[Q_W-1:0];
    end
  endfunction

  // True when the two values have strictly opposite signs.
  function automatic logic opposite(input logic signed [Q_W-1:0] u,
                                    input logic signed [Q_W-1:0] v);
    opposite = (u < 0 && v > 0) || (u > 0 && v < 0);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/glw_div.sv
// Restoring divider, one quotient bit per cycle, shared by recurrence and weight.
`default_nettype none
module glw_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [glw_pkg::DVD_W-1:0] dividend,
  input  wire logic [glw_pkg::DVS_W-1:0] divisor,
  input  wire logic [glw_pkg::ITER_W-1:0] iters,
  output logic                           done,
  output logic [glw_pkg::DVD_W-1:0]      quotient
);
  import glw_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W:0]    rem_sh;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        quo_r <= {quo_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: hw/rtl/glw_ctrl.sv
// Controller state machine: scan, bisection, weight and polynomial sequencing.
`default_nettype none
module glw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire glw_pkg::sts_t sts,
  output glw_pkg::cmd_t      cmd,
  output logic               busy
);
  import glw_pkg::*;

  typedef enum logic [27:0] {
    S_IDLE      = 28'h0000001,
    S_SCAN_L    = 28'h0000002,
    S_SCAN_LR   = 28'h0000004,
    S_SCAN_CHK  = 28'h0000008,
    S_SCAN_RR   = 28'h0000010,
    S_NODE_INIT = 28'h0000020,
    S_PA        = 28'h0000040,
    S_PA_R      = 28'h0000080,
    S_BIS_CHK   = 28'h0000100,
    S_PC_R      = 28'h0000200,
    S_WT1       = 28'h0000400,
    S_WT2       = 28'h0000800,
    S_WT3       = 28'h0001000,
    S_WT4       = 28'h0002000,
    S_WT5       = 28'h0004000,
    S_WT6       = 28'h0008000,
    S_WT7       = 28'h0010000,
    S_OUT       = 28'h0020000,
    S_NONE      = 28'h0040000,
    E_START     = 28'h0080000,
    E_CHK       = 28'h0100000,
    E_MUL       = 28'h0200000,
    E_RND       = 28'h0400000,
    E_NUM1      = 28'h0800000,
    E_NUM2      = 28'h1000000,
    E_DIVS      = 28'h2000000,
    E_DIVW      = 28'h4000000,
    E_UPD       = 28'h8000000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  // Next state and commands; E_* states form the shared polynomial routine.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && !sts.deg_zero) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_SCAN_L;
        end
      end
      S_SCAN_L: begin
        cmd.ev_load = 1'b1;
        cmd.ev_sel  = EV_X;
        ret_nxt     = S_SCAN_LR;
        state_nxt   = E_START;
      end
      S_SCAN_LR: begin
        cmd.pref_load = 1'b1;
        state_nxt     = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.scan_more) begin
          cmd.ev_load = 1'b1;
          cmd.ev_sel  = EV_XSTEP;
          ret_nxt     = S_SCAN_RR;
          state_nxt   = E_START;
        end else if (sts.cnt_zero) begin
          state_nxt = S_NONE;
        end else begin
          state_nxt = S_NODE_INIT;
        end
      end
      S_SCAN_RR: begin
        cmd.scan_adv = 1'b1;
        state_nxt    = S_SCAN_CHK;
      end
      S_NODE_INIT: begin
        cmd.node_init = 1'b1;
        state_nxt     = S_PA;
      end
      S_PA: begin
        cmd.ev_load = 1'b1;
        cmd.ev_sel  = EV_A;
        ret_nxt     = S_PA_R;
        state_nxt   = E_START;
      end
      S_PA_R: begin
        cmd.pref_load = 1'b1;
        state_nxt     = S_BIS_CHK;
      end
      S_BIS_CHK: begin
        if (sts.bis_more) begin
          cmd.ev_load = 1'b1;
          cmd.ev_sel  = EV_MID;
          ret_nxt     = S_PC_R;
          state_nxt   = E_START;
        end else begin
          cmd.c_latch = 1'b1;
          state_nxt   = S_WT1;
        end
      end
      S_PC_R: begin
        cmd.bis_upd = 1'b1;
        state_nxt   = S_BIS_CHK;
      end
      S_WT1: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_CC;
        state_nxt   = S_WT2;
      end
      S_WT2: begin
        cmd.omx_load = 1'b1;
        cmd.ev_load  = 1'b1;
        cmd.ev_sel   = EV_C;
        cmd.ev_nm1   = 1'b1;
        ret_nxt      = S_WT3;
        state_nxt    = E_START;
      end
      S_WT3: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_PP;
        state_nxt   = S_WT4;
      end
      S_WT4: begin
        cmd.q_load = 1'b1;
        state_nxt  = S_WT5;
      end
      S_WT5: begin
        cmd.den_load = 1'b1;
        state_nxt    = S_WT6;
      end
      S_WT6: begin
        if (sts.den_zero) begin
          cmd.w_sat = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_go_wt = 1'b1;
          state_nxt     = S_WT7;
        end
      end
      S_WT7: begin
        if (sts.div_done) begin
          cmd.w_load = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.last_node ? S_IDLE : S_NODE_INIT;
      end
      S_NONE: begin
        cmd.emit_none = 1'b1;
        state_nxt     = S_IDLE;
      end
      E_START: begin
        cmd.ev_init = 1'b1;
        state_nxt   = E_CHK;
      end
      E_CHK: begin
        state_nxt = sts.eval_done ? ret_r : E_MUL;
      end
      E_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_PX;
        state_nxt   = E_RND;
      end
      E_RND: begin
        cmd.t_load = 1'b1;
        state_nxt  = E_NUM1;
      end
      E_NUM1: begin
        cmd.num1  = 1'b1;
        state_nxt = E_NUM2;
      end
      E_NUM2: begin
        cmd.num2  = 1'b1;
        state_nxt = E_DIVS;
      end
      E_DIVS: begin
        cmd.div_go_rec = 1'b1;
        state_nxt      = E_DIVW;
      end
      E_DIVW: begin
        if (sts.div_done) begin
          state_nxt = E_UPD;
        end
      end
      E_UPD: begin
        cmd.ev_upd = 1'b1;
        state_nxt  = E_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

FILE: hw/rtl/glw_dp.sv
// Datapath: recurrence arithmetic, scan and bisection registers, weight and results.
`default_nettype none
`include "gauss_legendre_node_weight_generator_macros.svh"
module glw_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire glw_pkg::cmd_t                     cmd,
  output glw_pkg::sts_t                          sts,
  input  wire logic [glw_pkg::DEG_W-1:0]         in_degree,
  input  wire logic [glw_pkg::STEP_W-1:0]        cfg_step,
  input  wire logic [glw_pkg::SW_W-1:0]          cfg_sw,
  output logic                                   out_valid,
  output logic signed [glw_pkg::Q_W-1:0]         out_node,
  output logic [glw_pkg::Q_W-1:0]                out_weight,
  output logic [glw_pkg::IDX_W-1:0]              out_node_index,
  output logic                                   out_last,
  output logic                                   out_status
);
  import glw_pkg::*;

  logic [DEG_W-1:0]        n_r;
  logic [NSQ_W-1:0]        nsq_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        i_r;
  logic signed [Q_W-1:0]   x_r;
  logic signed [Q_W-1:0]   pref_r;
  logic signed [Q_W-1:0]   lo_r [MAX_DEGREE];
  logic signed [Q_W-1:0]   a_r, b_r, c_r;
  logic signed [Q_W-1:0]   ev_x_r;
  logic [DEG_W-1:0]        ev_n_r;
  logic [DEG_W-1:0]        k_r;
  logic signed [Q_W-1:0]   p0_r, p1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [T_W-1:0]   t_r;
  logic signed [NUM_W-1:0] num_r;
  logic [OMX_W-1:0]        omx_r;
  logic [QSQ_W-1:0]        q_r;
  logic [DVS_W-1:0]        den_r;
  logic [Q_W-1:0]          w_r;

  logic                    out_valid_r, out_last_r, out_status_r;
  logic signed [Q_W-1:0]   out_node_r;
  logic [Q_W-1:0]          out_weight_r;
  logic [IDX_W-1:0]        out_idx_r;

  logic [DEG_W-1:0]        deg_eff;
  logic [STEP_W-1:0]       step_eff;
  logic [SW_W-1:0]         sw_eff;
  logic signed [Q_W:0]     x_step;
  logic signed [Q_W:0]     lo_step;
  logic signed [Q_W:0]     ab_sum;
  logic signed [Q_W:0]     ab_diff;
  logic signed [Q_W-1:0]   mid;
  logic signed [Q_W-1:0]   mul_a, mul_b;
  logic signed [T_W-1:0]   prod_rnd;
  logic signed [T_W-1:0]   omx_full;
  logic signed [6:0]       kodd_s;
  logic signed [5:0]       km1_s;
  logic [NUM_W-1:0]        num_mag;
  logic signed [NUM_W:0]   pk;
  logic                    div_start;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic [ITER_W-1:0]       div_iters;
  logic                    div_done;
  logic [DVD_W-1:0]        div_quo;
  logic [DVD_W-1:0]        wt_dvd;
  logic                    last_node;

  // Clamped item and configuration values.
  assign deg_eff  = (in_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : in_degree;
  assign step_eff = (cfg_step == '0) ? STEP_W'(1) : cfg_step;
  assign sw_eff   = (cfg_sw < SW_MIN) ? SW_MIN : cfg_sw;

  // Scan and bisection arithmetic, one bit wider than the Q values.
  assign x_step  = {x_r[Q_W-1], x_r} + $signed({2'b0, step_eff});
  assign lo_step = {lo_r[i_r][Q_W-1], lo_r[i_r]} + $signed({2'b0, step_eff});
  assign ab_sum  = {a_r[Q_W-1], a_r} + {b_r[Q_W-1], b_r};
  assign ab_diff = {b_r[Q_W-1], b_r} - {a_r[Q_W-1], a_r};
  assign mid     = ab_sum[Q_W:1];

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_PX: begin
        mul_a = p1_r;
        mul_b = ev_x_r;
      end
      MUL_CC: begin
        mul_a = c_r;
        mul_b = c_r;
      end
      MUL_PP: begin
        mul_a = p1_r;
        mul_b = p1_r;
      end
      default: begin
        mul_a = p1_r;
        mul_b = ev_x_r;
      end
    endcase
  end

  // Recurrence coefficients and the signed quotient.
  assign prod_rnd = q_round(prod_r);
  assign kodd_s   = $signed({1'b0, 6'({k_r, 1'b0} - 6'd1)});
  assign km1_s    = $signed({1'b0, k_r - 5'd1});
  assign num_mag  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign pk       = num_r[NUM_W-1] ? -$signed({1'b0, div_quo[NUM_W-1:0]})
                                   : $signed({1'b0, div_quo[NUM_W-1:0]});
  assign omx_full = $signed({2'b0, ONE_Q}) - prod_rnd;
  assign wt_dvd   = {2'b0, omx_r, 31'b0} + {24'b0, den_r[DVS_W-1:1]};

  // Divider operands: recurrence by k, or weight numerator by denominator.
  assign div_start = cmd.div_go_rec | cmd.div_go_wt;
  assign div_dvd   = cmd.div_go_wt ? wt_dvd : {num_mag, 24'b0};
  assign div_dvs   = cmd.div_go_wt ? den_r : {36'b0, k_r};
  assign div_iters = cmd.div_go_wt ? WT_DIV_ITERS : REC_DIV_ITERS;

  glw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign last_node = (CNT_W'({1'b0, i_r}) + CNT_W'(1)) == cnt_r;

  // Status to the controller.
  always_comb begin
    sts.deg_zero  = (in_degree == '0);
    sts.eval_done = (k_r > ev_n_r);
    sts.div_done  = div_done;
    sts.scan_more = (x_step <= $signed({1'b0, ONE_Q})) && (cnt_r < CNT_W'(n_r));
    sts.cnt_zero  = (cnt_r == '0);
    sts.bis_more  = ab_diff >= $signed({12'b0, sw_eff});
    sts.den_zero  = (den_r == '0);
    sts.last_node = last_node;
  end

  // Control registers: counters and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | cmd.emit_none;
      if (cmd.item_load) begin
        cnt_r <= '0;
        i_r   <= '0;
      end
      if (cmd.scan_adv && opposite(pref_r, p1_r)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        i_r <= i_r + IDX_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      n_r   <= deg_eff;
      nsq_r <= NSQ_W'(deg_eff) * NSQ_W'(deg_eff);
      x_r   <= NEG_ONE_Q;
    end
    if (cmd.ev_load) begin
      unique case (cmd.ev_sel)
        EV_X:     ev_x_r <= x_r;
        EV_XSTEP: ev_x_r <= x_step[Q_W-1:0];
        EV_A:     ev_x_r <= a_r;
        EV_MID:   ev_x_r <= mid;
        EV_C:     ev_x_r <= c_r;
        default:  ev_x_r <= x_r;
      endcase
      ev_n_r <= cmd.ev_nm1 ? n_r - DEG_W'(1) : n_r;
    end
    if (cmd.ev_init) begin
      p0_r <= ONE_Q;
      p1_r <= (ev_n_r == '0) ? ONE_Q : ev_x_r;
      k_r  <= DEG_W'(2);
    end
    if (cmd.mul_go) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.t_load) begin
      t_r <= prod_rnd;
    end
    if (cmd.num1) begin
      num_r <= kodd_s * t_r;
    end
    if (cmd.num2) begin
      num_r <= num_r - km1_s * p0_r;
    end
    if (cmd.ev_upd) begin
      p0_r <= p1_r;
      p1_r <= sat32(pk);
      k_r  <= k_r + DEG_W'(1);
    end
    if (cmd.pref_load) begin
      pref_r <= p1_r;
    end
    if (cmd.scan_adv) begin
      if (opposite(pref_r, p1_r)) begin
        lo_r[cnt_r[IDX_W-1:0]] <= x_r;
      end
      x_r    <= x_step[Q_W-1:0];
      pref_r <= p1_r;
    end
    if (cmd.node_init) begin
      a_r <= lo_r[i_r];
      b_r <= lo_step[Q_W-1:0];
    end
    if (cmd.bis_upd) begin
      if (opposite(pref_r, p1_r)) begin
        b_r <= mid;
      end else begin
        a_r    <= mid;
        pref_r <= p1_r;
      end
    end
    if (cmd.c_latch) begin
      c_r <= mid;
    end
    if (cmd.omx_load) begin
      omx_r <= omx_full[T_W-1] ? '0 : omx_full[OMX_W-1:0];
    end
    if (cmd.q_load) begin
      q_r <= prod_rnd[QSQ_W-1:0];
    end
    if (cmd.den_load) begin
      den_r <= {8'b0, q_r} * {32'b0, nsq_r};
    end
    if (cmd.w_sat) begin
      w_r <= WEIGHT_MAX;
    end
    if (cmd.w_load) begin
      w_r <= (div_quo > {32'b0, WEIGHT_MAX}) ? WEIGHT_MAX : div_quo[Q_W-1:0];
    end
    if (cmd.emit) begin
      out_node_r   <= c_r;
      out_weight_r <= w_r;
      out_idx_r    <= i_r;
      out_last_r   <= last_node;
      out_status_r <= last_node && (cnt_r < CNT_W'(n_r));
    end
    if (cmd.emit_none) begin
      out_node_r   <= '0;
      out_weight_r <= '0;
      out_idx_r    <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node       = out_node_r;
  assign out_weight     = out_weight_r;
  assign out_node_index = out_idx_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

  // A result is strobed the cycle after the emit command.
  `GLW_ASSERT_NXT(a_emit_strobe, cmd.emit || cmd.emit_none, out_valid_r, "missing result strobe")
  // Short-run status only appears on the final result.
  `GLW_ASSERT_IMP(a_status_last, out_valid_r && out_status_r, out_last_r, "status on non-final result")
  // The divider never completes right after a start.
  `GLW_ASSERT_NXT(a_div_run, div_start, !div_done, "divider done too early")

endmodule
`default_nettype wire

FILE: hw/rtl/gauss_legendre_node_weight_generator.sv
// Top level of the Gauss-Legendre node and weight generator.
//
// Usage: set scan_step (index 0) and stop_width (index 1) through the cfg_
// write channel, which is always ready; write only while busy is low.
// A transaction on the command channel starts when start is high and busy
// is low; in_degree gives n (0 gives no result, above 16 counts as 16).
// The block then emits one result per node in ascending order, each held
// for a single cycle under out_valid, with out_last on the final one and
// out_status set there if fewer than n sign changes were found. If none
// were found a single zero result with last and status set is emitted.
// The receiver cannot stall; results are simply strobed.
// Each recurrence term of a polynomial evaluation waits on a 40-step serial
// divide. The scan costs one evaluation per grid point (up to 2/scan_step
// points), each node adds one evaluation per bisection halving, one at the
// lower bracket end, one of P_{n-1} for the weight, and the weight divide
// with its surrounding steps. One item is processed at a time.
// Reset (synchronous, rst_n low) restores the register defaults and idles.
`default_nettype none
module gauss_legendre_node_weight_generator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [glw_pkg::DEG_W-1:0]          in_degree,
  output logic                                    out_valid,
  output logic signed [glw_pkg::Q_W-1:0]          out_node,
  output logic [glw_pkg::Q_W-1:0]                 out_weight,
  output logic [glw_pkg::IDX_W-1:0]               out_node_index,
  output logic                                    out_last,
  output logic                                    out_status,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [glw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [glw_pkg::STEP_W-1:0]         cfg_data
);
  import glw_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [SW_W-1:0]   sw_r;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      sw_r   <= SW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCAN_STEP:  step_r <= cfg_data;
        CFG_STOP_WIDTH: sw_r   <= cfg_data[SW_W-1:0];
        default:        step_r <= step_r;
      endcase
    end
  end

  glw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  glw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_degree      (in_degree),
    .cfg_step       (step_r),
    .cfg_sw         (sw_r),
    .out_valid      (out_valid),
    .out_node       (out_node),
    .out_weight     (out_weight),
    .out_node_index (out_node_index),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

FILE: dv/glw_checker.sv
// Checker for the Gauss-Legendre generator: predicts nodes and weights and compares results.
`default_nettype none
module glw_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [glw_pkg::DEG_W-1:0]     in_degree,
  input  wire logic                          out_valid,
  input  wire logic [glw_pkg::Q_W-1:0]       out_node,
  input  wire logic [glw_pkg::Q_W-1:0]       out_weight,
  input  wire logic [glw_pkg::IDX_W-1:0]     out_node_index,
  input  wire logic                          out_last,
  input  wire logic                          out_status,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [glw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [glw_pkg::STEP_W-1:0]    cfg_data,
  output int                                 errors,
  output int                                 pending
);
  import glw_pkg::*;

  typedef struct packed {
    logic [Q_W-1:0]   node;
    logic [Q_W-1:0]   weight;
    logic [IDX_W-1:0] node_index;
    logic             last;
    logic             status;
  } node_result_t;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  node_result_t expected_nodes[$];
  logic [STEP_W-1:0] step_reg;
  logic [SW_W-1:0]   width_reg;

  // Rounds a full product back to the fraction width, ties away from zero.
  function automatic longint fix_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // P_n(x) by the three-term recurrence.
  function automatic longint legendre_at(longint x, int n);
    longint p_prev;
    longint p_cur;
    longint num;
    longint nxt;
    p_prev = ONE;
    p_cur = clip32(x);
    if (n == 0) return p_prev;
    for (int k = 2; k <= n; k++) begin
      num = longint'(2 * k - 1) * fix_mul(p_cur, clip32(x)) - longint'(k - 1) * p_prev;
      nxt = clip32(num / k);
      p_prev = p_cur;
      p_cur = nxt;
    end
    return p_cur;
  endfunction

  function automatic bit sign_flip(longint u, longint v);
    return (u < 0 && v > 0) || (u > 0 && v < 0);
  endfunction

  // Scans for brackets, bisects each one and queues the node and weight results.
  task automatic predict_nodes(int deg);
    longint lows[MAX_DEGREE];
    longint step;
    longint sw;
    longint x;
    longint pl;
    longint pr;
    longint a;
    longint b;
    longint c;
    longint omx;
    longint q;
    longint den;
    longint unsigned w;
    int n;
    int cnt;
    node_result_t r;
    n = deg;
    if (n == 0) return;
    if (n > MAX_DEGREE) n = MAX_DEGREE;
    step = (step_reg == 0) ? 1 : longint'(step_reg);
    sw = (width_reg < SW_MIN) ? longint'(SW_MIN) : longint'(width_reg);
    cnt = 0;
    x = -ONE;
    pl = legendre_at(x, n);
    while (x + step <= ONE && cnt < n) begin
      pr = legendre_at(x + step, n);
      if (sign_flip(pl, pr)) begin
        lows[cnt] = x;
        cnt++;
      end
      x += step;
      pl = pr;
    end
    if (cnt == 0) begin
      r = '0;
      r.last = 1'b1;
      r.status = 1'b1;
      expected_nodes.push_back(r);
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      a = lows[i];
      b = lows[i] + step;
      c = (a + b) >>> 1;
      while (b - a >= sw) begin
        if (sign_flip(legendre_at(a, n), legendre_at(c, n))) b = c;
        else a = c;
        c = (a + b) >>> 1;
      end
      omx = ONE - fix_mul(c, c);
      if (omx < 0) omx = 0;
      q = fix_mul(legendre_at(c, n - 1), legendre_at(c, n - 1));
      den = longint'(n * n) * q;
      if (den <= 0) begin
        w = 64'h8000_0000;
      end else begin
        w = ((longint'(2 * omx) << FRAC_BITS) + den / 2) / den;
        if (w > 64'h8000_0000) w = 64'h8000_0000;
      end
      r.node = c[Q_W-1:0];
      r.weight = w[Q_W-1:0];
      r.node_index = i[IDX_W-1:0];
      r.last = (i == cnt - 1);
      r.status = (i == cnt - 1) && (cnt < n);
      expected_nodes.push_back(r);
    end
  endtask

  assign pending = expected_nodes.size();

  // Track register writes, predict on accepted commands and compare each result.
  always @(posedge clk) begin
    node_result_t got;
    node_result_t exp_r;
    if (!rst_n) begin
      step_reg <= STEP_RESET;
      width_reg <= SW_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SCAN_STEP) step_reg <= cfg_data;
        else width_reg <= cfg_data[SW_W-1:0];
      end
      if (start && !busy) predict_nodes(int'(in_degree));
      if (out_valid) begin
        got = {out_node, out_weight, out_node_index, out_last, out_status};
        if (expected_nodes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result transaction: %p", got);
        end else begin
          exp_r = expected_nodes.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected node %0d weight %0d index %0d last %0b status %0b, got node %0d weight %0d index %0d last %0b status %0b",
                       $signed(exp_r.node), exp_r.weight, exp_r.node_index, exp_r.last,
                       exp_r.status, $signed(got.node), got.weight, got.node_index,
                       got.last, got.status);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Top of the testbench: clock, reset, command and register stimulus, and the verdict.
`default_nettype none
module testbench;
  import glw_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [DEG_W-1:0] in_degree = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCAN_STEP;
  logic [STEP_W-1:0] cfg_data = '0;
  logic busy;
  logic out_valid;
  logic [Q_W-1:0] out_node;
  logic [Q_W-1:0] out_weight;
  logic [IDX_W-1:0] out_node_index;
  logic out_last;
  logic out_status;
  logic cfg_ready;
  int errors;
  int pending;
  bit gaps_on = 1'b1;

  always #5 clk = ~clk;

  gauss_legendre_node_weight_generator dut (.*);

  glw_checker checker_i (.*);

  // Random idle cycles before a transaction.
  task automatic idle_gap();
    while (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One command transaction; start stays high if the next one follows directly.
  task automatic run_degree(logic [DEG_W-1:0] deg);
    idle_gap();
    start <= 1'b1;
    in_degree <= deg;
    do @(posedge clk); while (busy);
  endtask

  // Waits until every expected result has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  // One register write; the channel then rests idle before the task returns.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
    idle_gap();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [STEP_W-1:0] step, logic [STEP_W-1:0] sw);
    drain();
    write_reg(CFG_SCAN_STEP, step);
    write_reg(CFG_STOP_WIDTH, sw);
    @(posedge clk);
  endtask

  // Mostly small degrees keep the scan short; a few large and out-of-range ones.
  function automatic logic [DEG_W-1:0] pick_degree();
    int r;
    r = $urandom_range(99);
    if (r < 78) return DEG_W'($urandom_range(0, 6));
    if (r < 94) return DEG_W'($urandom_range(7, 16));
    return DEG_W'($urandom_range(17, 31));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults at degree one, then a degree of zero.
    run_degree(5'd1);
    run_degree(5'd0);

    // Zero step and stop width are written but no item runs with them; then a half-range
    // step puts the root of degree one exactly on a grid point, and a stop width of one is raised.
    set_regs('0, '0);
    write_reg(CFG_SCAN_STEP, 31'h4000_0000);
    write_reg(CFG_STOP_WIDTH, 31'd1);
    run_degree(5'd2);
    run_degree(5'd3);
    run_degree(5'd16);
    run_degree(5'd17);
    run_degree(5'd31);
    run_degree(5'd0);
    run_degree(5'd1);

    // Largest step leaves room for a single bracket at most.
    set_regs(31'h7FFF_FFFF, 31'h1F_FFFF);
    run_degree(5'd4);
    run_degree(5'd8);

    // Coarse grid with widest stop width; some roots share a bracket.
    set_regs(31'h0400_0000, 31'h1F_FFFF);
    for (int d = 1; d <= 16; d += 3) run_degree(DEG_W'(d));
    run_degree(5'd16);

    // Random phases with random registers.
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(STEP_W'($urandom_range(32'h0100_0000, 32'h1000_0000)),
               STEP_W'($urandom_range(2, 32'h10_0000)));
      gaps_on = (ph != 3);
      for (int i = 0; i < 12; i++) run_degree(pick_degree());
    end
    gaps_on = 1'b1;

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    repeat (200_000_000) @(posedge clk);
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/glw_pkg.sv
hw/rtl/glw_div.sv
hw/rtl/glw_ctrl.sv
hw/rtl/glw_dp.sv
hw/rtl/gauss_legendre_node_weight_generator.sv
dv/glw_checker.sv
dv/testbench.sv
